/* src/rrts_pkg.sv */
// Shared types and codes for the round-robin task scheduler.
package rrts_pkg;

   // request types
   localparam logic [3:0] REQ_TICK     = 4'd0;
   localparam logic [3:0] REQ_YIELD    = 4'd1;
   localparam logic [3:0] REQ_PREEMPT  = 4'd2;
   localparam logic [3:0] REQ_BLOCK    = 4'd3;
   localparam logic [3:0] REQ_NET_WAKE = 4'd4;
   localparam logic [3:0] REQ_CREATE   = 4'd5;
   localparam logic [3:0] REQ_KILL     = 4'd6;
   localparam logic [3:0] REQ_EXIT     = 4'd7;
   localparam logic [3:0] REQ_SET_IDLE = 4'd8;

   // slot states
   localparam logic [2:0] SS_UNUSED  = 3'd0;
   localparam logic [2:0] SS_READY   = 3'd1;
   localparam logic [2:0] SS_RUNNING = 3'd2;
   localparam logic [2:0] SS_BLOCKED = 3'd3;
   localparam logic [2:0] SS_ZOMBIE  = 3'd4;

   // wait kinds
   localparam logic [1:0] WK_NONE  = 2'd0;
   localparam logic [1:0] WK_SLEEP = 2'd1;
   localparam logic [1:0] WK_NET   = 2'd2;

   // response status
   localparam logic [1:0] RS_OK        = 2'd0;
   localparam logic [1:0] RS_NOT_FOUND = 2'd1;
   localparam logic [1:0] RS_PROTECTED = 2'd2;

   // datapath operations
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_WAKE     = 5'd2;
   localparam logic [4:0] OP_NET_WAKE = 5'd3;
   localparam logic [4:0] OP_PICK     = 5'd4;
   localparam logic [4:0] OP_CREATE   = 5'd5;
   localparam logic [4:0] OP_TICK_END = 5'd6;
   localparam logic [4:0] OP_Y_PREP   = 5'd7;
   localparam logic [4:0] OP_Y_END    = 5'd8;
   localparam logic [4:0] OP_BLOCK    = 5'd9;
   localparam logic [4:0] OP_B_END    = 5'd10;
   localparam logic [4:0] OP_NET_END  = 5'd11;
   localparam logic [4:0] OP_KILL     = 5'd12;
   localparam logic [4:0] OP_EXIT     = 5'd13;
   localparam logic [4:0] OP_X_END    = 5'd14;
   localparam logic [4:0] OP_SET_IDLE = 5'd15;
   localparam logic [4:0] OP_FINISH   = 5'd16;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic create_hit;
      logic expired;
      logic kill_exit;
      logic preempt_ok;
      logic out_free;
   } stat_type;

endpackage

/* src/rrts_dp.sv */
// Scheduler datapath: slot table, scan counter, pick tracking and response register.
module rrts_dp #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rrts_pkg::cmd_type   cmd,
   output rrts_pkg::stat_type  stat,
   input  logic [3:0]          req_type,
   input  logic [31:0]         req_now_ms,
   input  logic [3:0]          req_target_slot,
   input  logic [31:0]         req_deadline_ms,
   input  logic [1:0]          req_block_reason,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_switched,
   output logic [3:0]          rsp_running_slot,
   output logic [3:0]          rsp_created_slot,
   output logic                rsp_resched_flag
);
   import rrts_pkg::*;

   localparam int IW = $clog2(SLOTS);

   logic [2:0]    st_ff   [SLOTS];
   logic          idle_ff [SLOTS];
   logic [31:0]   dl_ff   [SLOTS];
   logic [1:0]    wk_ff   [SLOTS];

   logic [IW-1:0] cur_ff, cur_in, cnt_ff, cnt_in;
   logic [15:0]   slice_ff, slice_in, ticks_ff;
   logic          resched_ff, resched_in, woke_ff, woke_in;
   logic          fnd_ff, fnd_in, ipk_ff, ipk_in;
   logic [IW-1:0] fnd_slot_ff, fnd_slot_in, ipk_slot_ff, ipk_slot_in;
   logic [31:0]   now_ff, rdl_ff;
   logic [3:0]    tgt_ff;
   logic [1:0]    rsn_ff;
   logic [IW-1:0] before_ff, before_in, created_ff, created_in;
   logic [1:0]    code_ff, code_in;
   logic          rsp_valid_ff;
   logic [1:0]    o_status_ff;
   logic          o_switched_ff, o_resched_ff;
   logic [3:0]    o_running_ff, o_created_ff;

   logic [IW:0]   psum;
   logic [IW-1:0] paddr, pk_slot, tgt_ix, addr, ix;
   logic          pk_valid, tgt_oob;
   logic [2:0]    rs;
   logic          ri;
   logic [31:0]   rdl, wdiff, bdiff;
   logic [1:0]    rk, rsn_fix;
   logic          wake_due, expired, kill_exit;
   logic          e_we;
   logic [2:0]    e_st;
   logic          e_idle;
   logic [31:0]   e_dl;
   logic [1:0]    e_wk;

   // pick scan walks from the slot after the current one, wrapping
   assign psum  = {1'b0, cur_ff} + {1'b0, cnt_ff} + (IW+1)'(1);
   assign paddr = (psum >= (IW+1)'(SLOTS)) ? IW'(psum - (IW+1)'(SLOTS)) : psum[IW-1:0];

   assign pk_valid = fnd_ff | ipk_ff;
   assign pk_slot  = fnd_ff ? fnd_slot_ff : ipk_slot_ff;
   assign tgt_oob  = {28'd0, tgt_ff} >= 32'(SLOTS);
   assign tgt_ix   = IW'(tgt_ff);

   always_comb begin
      case (cmd.op)
         OP_WAKE, OP_NET_WAKE, OP_CREATE: addr = cnt_ff;
         OP_PICK:                          addr = paddr;
         OP_Y_END, OP_B_END:               addr = (pk_valid && pk_slot != cur_ff) ? pk_slot : cur_ff;
         OP_X_END:                         addr = pk_valid ? pk_slot : '0;
         OP_KILL, OP_SET_IDLE:             addr = tgt_ix;
         default:                          addr = cur_ff;
      endcase
   end

   assign ix  = ({{(32-IW){1'b0}}, addr} < 32'(SLOTS)) ? addr : '0;
   assign rs  = st_ff[ix];
   assign ri  = idle_ff[ix];
   assign rdl = dl_ff[ix];
   assign rk  = wk_ff[ix];

   assign wdiff    = now_ff - rdl;
   assign wake_due = (rs == SS_BLOCKED) && (rdl != 32'd0) && !wdiff[31];
   assign bdiff    = now_ff - rdl_ff;
   assign expired  = (rdl_ff != 32'd0) && !bdiff[31];
   assign rsn_fix  = (rsn_ff == WK_SLEEP || rsn_ff == WK_NET) ? rsn_ff : WK_SLEEP;
   assign kill_exit = !tgt_oob && rs != SS_UNUSED && tgt_ff != 4'd0 && !ri
                      && rs != SS_ZOMBIE && tgt_ix == cur_ff;

   always_comb begin
      cur_in      = cur_ff;
      cnt_in      = '0;
      slice_in    = slice_ff;
      resched_in  = resched_ff;
      woke_in     = woke_ff;
      fnd_in      = fnd_ff;
      fnd_slot_in = fnd_slot_ff;
      ipk_in      = ipk_ff;
      ipk_slot_in = ipk_slot_ff;
      before_in   = before_ff;
      created_in  = created_ff;
      code_in     = code_ff;
      e_we        = 1'b0;
      e_st        = rs;
      e_idle      = ri;
      e_dl        = rdl;
      e_wk        = rk;
      case (cmd.op)
         OP_LOAD: begin
            before_in  = cur_ff;
            woke_in    = 1'b0;
            fnd_in     = 1'b0;
            ipk_in     = 1'b0;
            created_in = '0;
            code_in    = (req_type == REQ_CREATE) ? RS_NOT_FOUND : RS_OK;
         end
         OP_WAKE, OP_NET_WAKE: begin
            cnt_in = cnt_ff + IW'(1);
            if ((cmd.op == OP_WAKE && wake_due) ||
                (cmd.op == OP_NET_WAKE && rs == SS_BLOCKED && rk == WK_NET)) begin
               e_we = 1'b1;
               e_st = SS_READY;
               e_dl = 32'd0;
               e_wk = WK_NONE;
               if (addr == cur_ff) woke_in = 1'b1;
            end
         end
         OP_PICK: begin
            cnt_in = cnt_ff + IW'(1);
            if (rs == SS_READY) begin
               if (!ri && !fnd_in) begin
                  fnd_in      = 1'b1;
                  fnd_slot_in = addr;
               end
               if (ri && !ipk_ff) begin
                  ipk_in      = 1'b1;
                  ipk_slot_in = addr;
               end
            end
         end
         OP_CREATE: begin
            cnt_in = cnt_ff + IW'(1);
            // a zombie is reclaimed and then taken at once
            if (rs == SS_ZOMBIE || rs == SS_UNUSED) begin
               e_we       = 1'b1;
               e_st       = SS_READY;
               e_idle     = 1'b0;
               e_dl       = 32'd0;
               e_wk       = WK_NONE;
               created_in = addr;
               code_in    = RS_OK;
            end
         end
         OP_TICK_END: begin
            if (woke_ff) begin
               e_we       = 1'b1;
               e_st       = SS_RUNNING;
               e_wk       = WK_NONE;
               slice_in   = ticks_ff;
               resched_in = 1'b0;
            end else if (slice_ff <= 16'd1) begin
               resched_in = 1'b1;
               slice_in   = ticks_ff;
            end else begin
               slice_in = slice_ff - 16'd1;
            end
         end
         OP_Y_PREP: begin
            if (woke_ff) begin
               slice_in   = ticks_ff;
               resched_in = 1'b0;
            end
            if (woke_ff || rs == SS_RUNNING) begin
               e_we = 1'b1;
               e_st = SS_READY;
               e_wk = woke_ff ? WK_NONE : rk;
            end
         end
         OP_Y_END: begin
            resched_in = 1'b0;
            if (pk_valid && pk_slot != cur_ff) begin
               e_we     = 1'b1;
               e_st     = SS_RUNNING;
               cur_in   = pk_slot;
               slice_in = ticks_ff;
            end else if (rs == SS_READY) begin
               e_we = 1'b1;
               e_st = SS_RUNNING;
            end
         end
         OP_BLOCK: begin
            if (!expired) begin
               e_we = 1'b1;
               e_st = SS_BLOCKED;
               e_wk = rsn_fix;
               e_dl = (rdl_ff != 32'd0) ? rdl_ff : 32'd1;
            end
         end
         OP_B_END: begin
            if (pk_valid) begin
               e_we       = 1'b1;
               e_st       = SS_RUNNING;
               cur_in     = pk_slot;
               slice_in   = ticks_ff;
               resched_in = 1'b0;
            end
         end
         OP_NET_END: begin
            if (woke_ff) begin
               e_we       = 1'b1;
               e_st       = SS_RUNNING;
               e_wk       = WK_NONE;
               slice_in   = ticks_ff;
               resched_in = 1'b0;
            end
         end
         OP_KILL: begin
            if (tgt_oob || rs == SS_UNUSED) begin
               code_in = RS_NOT_FOUND;
            end else if (tgt_ff == 4'd0 || ri) begin
               code_in = RS_PROTECTED;
            end else if (rs != SS_ZOMBIE && tgt_ix != cur_ff) begin
               e_we = 1'b1;
               e_st = SS_ZOMBIE;
               e_dl = 32'd0;
               e_wk = WK_NONE;
            end
         end
         OP_EXIT: begin
            e_we = 1'b1;
            e_st = SS_ZOMBIE;
            e_dl = 32'd0;
            e_wk = WK_NONE;
         end
         OP_X_END: begin
            e_we     = 1'b1;
            e_st     = SS_RUNNING;
            cur_in   = addr;
            slice_in = ticks_ff;
         end
         OP_SET_IDLE: begin
            if (tgt_oob || rs == SS_UNUSED) begin
               code_in = RS_NOT_FOUND;
            end else begin
               e_we   = 1'b1;
               e_idle = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            st_ff[i]   <= (i == 0) ? SS_RUNNING : SS_UNUSED;
            idle_ff[i] <= 1'b0;
         end
         cur_ff       <= '0;
         cnt_ff       <= '0;
         slice_ff     <= 16'd10;
         ticks_ff     <= 16'd10;
         resched_ff   <= 1'b0;
         woke_ff      <= 1'b0;
         fnd_ff       <= 1'b0;
         ipk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (e_we) begin
            st_ff[ix]   <= e_st;
            idle_ff[ix] <= e_idle;
         end
         cur_ff     <= cur_in;
         cnt_ff     <= cnt_in;
         slice_ff   <= slice_in;
         resched_ff <= resched_in;
         woke_ff    <= woke_in;
         fnd_ff     <= fnd_in;
         ipk_ff     <= ipk_in;
         if (csr_wr_en) ticks_ff <= csr_wr_data;
         if (cmd.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         dl_ff[ix] <= e_dl;
         wk_ff[ix] <= e_wk;
      end
      fnd_slot_ff <= fnd_slot_in;
      ipk_slot_ff <= ipk_slot_in;
      before_ff   <= before_in;
      created_ff  <= created_in;
      code_ff     <= code_in;
      if (cmd.op == OP_LOAD) begin
         now_ff <= req_now_ms;
         rdl_ff <= req_deadline_ms;
         tgt_ff <= req_target_slot;
         rsn_ff <= req_block_reason;
      end
      if (cmd.op == OP_FINISH) begin
         o_status_ff   <= code_ff;
         o_switched_ff <= cur_ff != before_ff;
         o_running_ff  <= 4'(cur_ff);
         o_created_ff  <= 4'(created_ff);
         o_resched_ff  <= resched_ff;
      end
   end

   assign stat.scan_last  = cnt_ff == IW'(SLOTS - 1);
   assign stat.create_hit = rs == SS_ZOMBIE || rs == SS_UNUSED;
   assign stat.expired    = expired;
   assign stat.kill_exit  = kill_exit;
   assign stat.preempt_ok = resched_ff && rs == SS_RUNNING;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_switched     = o_switched_ff;
   assign rsp_running_slot = o_running_ff;
   assign rsp_created_slot = o_created_ff;
   assign rsp_resched_flag = o_resched_ff;

endmodule

/* src/rrts_ctrl.sv */
// Scheduler controller: sequences the slot scans and single-slot steps of a request.
module rrts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_type,
   input  rrts_pkg::stat_type stat,
   output rrts_pkg::cmd_type  cmd
);
   import rrts_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CHECK    = 5'd1;
   localparam logic [4:0] S_WAKE     = 5'd2;
   localparam logic [4:0] S_TICK_END = 5'd3;
   localparam logic [4:0] S_Y_PREP   = 5'd4;
   localparam logic [4:0] S_PICK     = 5'd5;
   localparam logic [4:0] S_Y_END    = 5'd6;
   localparam logic [4:0] S_BLOCK    = 5'd7;
   localparam logic [4:0] S_B_END    = 5'd8;
   localparam logic [4:0] S_NET      = 5'd9;
   localparam logic [4:0] S_NET_END  = 5'd10;
   localparam logic [4:0] S_CREATE   = 5'd11;
   localparam logic [4:0] S_KILL     = 5'd12;
   localparam logic [4:0] S_EXIT     = 5'd13;
   localparam logic [4:0] S_X_END    = 5'd14;
   localparam logic [4:0] S_SET_IDLE = 5'd15;
   localparam logic [4:0] S_FIN      = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [3:0] kind_ff, kind_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op  = OP_LOAD;
               kind_in = req_type;
               case (req_type)
                  REQ_TICK, REQ_YIELD: state_in = S_WAKE;
                  REQ_PREEMPT:         state_in = S_CHECK;
                  REQ_BLOCK:           state_in = S_BLOCK;
                  REQ_NET_WAKE:        state_in = S_NET;
                  REQ_CREATE:          state_in = S_CREATE;
                  REQ_KILL:            state_in = S_KILL;
                  REQ_EXIT:            state_in = S_EXIT;
                  REQ_SET_IDLE:        state_in = S_SET_IDLE;
                  default:             state_in = S_FIN;
               endcase
            end
         end
         S_CHECK:    state_in = stat.preempt_ok ? S_WAKE : S_FIN;
         S_WAKE: begin
            cmd.op = OP_WAKE;
            if (stat.scan_last) state_in = (kind_ff == REQ_TICK) ? S_TICK_END : S_Y_PREP;
         end
         S_TICK_END: begin
            cmd.op   = OP_TICK_END;
            state_in = S_FIN;
         end
         S_Y_PREP: begin
            cmd.op   = OP_Y_PREP;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.op = OP_PICK;
            if (stat.scan_last) begin
               case (kind_ff)
                  REQ_BLOCK:          state_in = S_B_END;
                  REQ_EXIT, REQ_KILL: state_in = S_X_END;
                  default:            state_in = S_Y_END;
               endcase
            end
         end
         S_Y_END: begin
            cmd.op   = OP_Y_END;
            state_in = S_FIN;
         end
         S_BLOCK: begin
            cmd.op   = OP_BLOCK;
            state_in = stat.expired ? S_FIN : S_PICK;
         end
         S_B_END: begin
            cmd.op   = OP_B_END;
            state_in = S_FIN;
         end
         S_NET: begin
            cmd.op = OP_NET_WAKE;
            if (stat.scan_last) state_in = S_NET_END;
         end
         S_NET_END: begin
            cmd.op   = OP_NET_END;
            state_in = S_FIN;
         end
         S_CREATE: begin
            cmd.op = OP_CREATE;
            if (stat.create_hit || stat.scan_last) state_in = S_FIN;
         end
         S_KILL: begin
            cmd.op   = OP_KILL;
            // killing the running task goes down the exit path
            state_in = stat.kill_exit ? S_EXIT : S_FIN;
         end
         S_EXIT: begin
            cmd.op   = OP_EXIT;
            state_in = S_PICK;
         end
         S_X_END: begin
            cmd.op   = OP_X_END;
            state_in = S_FIN;
         end
         S_SET_IDLE: begin
            cmd.op   = OP_SET_IDLE;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= REQ_TICK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

/* src/round_robin_task_scheduler.sv */
// Round-robin task scheduler top level: controller, datapath and checks.
// One request at a time; each slot scan walks the slots through the single table port.
// Tick runs a wake scan and tick end; yield adds a prep step, a pick scan and the yield end;
// preempt checks resched first; block/exit run a pick scan; create scans for a free slot.
// A finished response waits in the output register while the next request is taken.
// Synchronous reset: slot 0 running, others unused, slice of 10 ticks, no reschedule.
module round_robin_task_scheduler #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [3:0]  req_target_slot,
   input  logic [31:0] req_deadline_ms,
   input  logic [1:0]  req_block_reason,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_switched,
   output logic [3:0]  rsp_running_slot,
   output logic [3:0]  rsp_created_slot,
   output logic        rsp_resched_flag,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import rrts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_dp #(.SLOTS(SLOTS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_now_ms       (req_now_ms),
      .req_target_slot  (req_target_slot),
      .req_deadline_ms  (req_deadline_ms),
      .req_block_reason (req_block_reason),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_switched     (rsp_switched),
      .rsp_running_slot (rsp_running_slot),
      .rsp_created_slot (rsp_created_slot),
      .rsp_resched_flag (rsp_resched_flag)
   );

   // only one request in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |=> rsp_valid)
      else $error("finished request not presented");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |-> stat.out_free)
      else $error("response register overwritten");

endmodule
